[sv/podu_pkg.sv]
// shared types, codes and dot packing functions of the planar octet draw unit
package podu_pkg;

  // access codes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_PEEK  = 2'd2;

  // register indexes
  localparam logic [2:0] REG_COLOUR = 3'd0;
  localparam logic [2:0] REG_BG_LOW = 3'd1;
  localparam logic [2:0] REG_BG_HIGH = 3'd2;
  localparam logic [2:0] REG_OCTET = 3'd3;
  localparam logic [2:0] REG_MASK = 3'd4;

  localparam int unsigned NUM_PLANES = 3;
  localparam int unsigned NUM_DOTS = 8;

  typedef logic [NUM_DOTS-1:0] plane_byte_t;
  typedef plane_byte_t [NUM_PLANES-1:0] planes_t;

  // input beat
  typedef struct packed {
    logic [1:0]  operation;
    logic [2:0]  reg_index;
    logic        byte_access;
    logic        byte_lane;
    logic [15:0] write_data;
    logic [15:0] screen_address;
    logic [7:0]  plane_zero_byte;
    logic [7:0]  plane_one_byte;
    logic [7:0]  plane_two_byte;
  } podu_in_t;

  // result beat
  typedef struct packed {
    logic [15:0] read_result;
    logic [2:0]  plane_write_enables;
    logic [15:0] plane_write_address;
    logic [7:0]  plane_zero_out;
    logic [7:0]  plane_one_out;
    logic [7:0]  plane_two_out;
  } podu_out_t;

  // spread the nibble dots of the two background words over three plane bytes
  function automatic planes_t bg_to_planes(input logic [15:0] lo, input logic [15:0] hi);
    planes_t pl;
    logic [31:0] both;
    both = {hi, lo};
    for (int k = 0; k < NUM_DOTS; k++) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        pl[p][k] = both[k*4 + p];
      end
    end
    return pl;
  endfunction

  // gather three plane bytes back into nibble dots, upper nibble bit clear
  function automatic logic [31:0] planes_to_bg(input planes_t pl);
    logic [31:0] both;
    both = '0;
    for (int k = 0; k < NUM_DOTS; k++) begin
      for (int p = 0; p < NUM_PLANES; p++) begin
        both[k*4 + p] = pl[p][k];
      end
    end
    return both;
  endfunction

endpackage

[sv/podu_exec.sv]
// register file and draw datapath: one access per fire, result combinational
module podu_exec import podu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  podu_in_t  item,
  output podu_out_t result
);

  logic [2:0]  fg_colour;
  logic [15:0] bg_low_word;
  logic [15:0] bg_high_word;
  logic [7:0]  last_octet;
  logic [2:0]  plane_inhibit;

  logic [2:0]  fg_colour_next;
  logic [15:0] bg_low_word_next;
  logic [15:0] bg_high_word_next;
  logic [7:0]  last_octet_next;
  logic [2:0]  plane_inhibit_next;

  logic [15:0] wval;
  logic [15:0] rword;
  logic [7:0]  octet;
  logic [31:0] packed_bg;
  planes_t     scr;
  planes_t     bgpl;
  planes_t     drawn;
  planes_t     newb;
  logic [2:0]  en;
  logic        is_read;
  logic        draw;

  // write value as placed on its lane
  always_comb begin
    if (item.byte_access) begin
      wval = item.byte_lane ? {item.write_data[7:0], 8'h00} : {8'h00, item.write_data[7:0]};
    end else begin
      wval = item.write_data;
    end
  end

  assign scr[0]    = item.plane_zero_byte;
  assign scr[1]    = item.plane_one_byte;
  assign scr[2]    = item.plane_two_byte;
  assign packed_bg = planes_to_bg(scr);
  assign octet     = wval[7:0];
  assign bgpl      = bg_to_planes(bg_low_word, bg_high_word);
  assign is_read   = (item.operation == OP_READ) || (item.operation == OP_PEEK);
  assign draw      = (item.operation == OP_WRITE) && (item.reg_index == REG_OCTET);

  // draw: set octet bits take the foreground colour
  always_comb begin
    for (int p = 0; p < NUM_PLANES; p++) begin
      drawn[p] = (bgpl[p] & ~octet) | (fg_colour[p] ? octet : 8'h00);
      en[p]    = draw && !plane_inhibit[p];
      newb[p]  = en[p] ? drawn[p] : 8'h00;
    end
  end

  // register read mux
  always_comb begin
    case (item.reg_index)
      REG_COLOUR:  rword = {13'd0, fg_colour};
      REG_BG_LOW:  rword = bg_low_word;
      REG_BG_HIGH: rword = bg_high_word;
      REG_MASK:    rword = {13'd0, plane_inhibit};
      default:     rword = 16'h0000;
    endcase
  end

  // result fields
  always_comb begin
    result = '0;
    if (is_read) begin
      if (item.byte_access) begin
        result.read_result = item.byte_lane ? {8'h00, rword[15:8]} : {8'h00, rword[7:0]};
      end else begin
        result.read_result = rword;
      end
    end
    result.plane_write_enables = en;
    result.plane_write_address = draw ? item.screen_address : 16'h0000;
    result.plane_zero_out      = newb[0];
    result.plane_one_out       = newb[1];
    result.plane_two_out       = newb[2];
  end

  // state update
  always_comb begin
    fg_colour_next     = fg_colour;
    bg_low_word_next   = bg_low_word;
    bg_high_word_next  = bg_high_word;
    last_octet_next    = last_octet;
    plane_inhibit_next = plane_inhibit;
    if (item.operation == OP_WRITE) begin
      case (item.reg_index)
        REG_COLOUR:  fg_colour_next = wval[2:0];
        REG_BG_LOW:  bg_low_word_next = wval;
        REG_BG_HIGH: bg_high_word_next = wval;
        REG_OCTET:   last_octet_next = octet;
        REG_MASK:    plane_inhibit_next = wval[2:0];
        default: begin
        end
      endcase
    end else if (item.operation == OP_READ && item.reg_index == REG_OCTET) begin
      bg_low_word_next  = packed_bg[15:0];
      bg_high_word_next = packed_bg[31:16];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_colour     <= '0;
      bg_low_word   <= '0;
      bg_high_word  <= '0;
      last_octet    <= '0;
      plane_inhibit <= '0;
    end else if (fire) begin
      fg_colour     <= fg_colour_next;
      bg_low_word   <= bg_low_word_next;
      bg_high_word  <= bg_high_word_next;
      last_octet    <= last_octet_next;
      plane_inhibit <= plane_inhibit_next;
    end
  end

endmodule

[sv/planar_octet_draw_unit_core.sv]
// top level of the planar octet draw unit: input register, datapath, result register
//
//   channel | direction | handshake       | payload
//   in      | input     | in_valid/stall  | podu_in_t  access beat
//   out     | output    | out_valid/stall | podu_out_t result beat
//
// one beat per cycle sustained while out_stall is low.
// the input register feeds the datapath, whose result lands in the result register.
// rst (synchronous) clears the valid flags and exec registers and empties both stages.
// out_stall holds the result register; the input register then fills and in_stall rises.
module planar_octet_draw_unit_core import podu_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  podu_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output podu_out_t out_data
);

  logic      s1_valid;
  podu_in_t  s1_item;
  logic      s1_fire;
  logic      out_free;
  podu_out_t result;

  assign out_free = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && out_free;
  assign in_stall = s1_valid && !out_free;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item <= in_data;
    end
  end

  podu_exec u_exec (
    .clk    (clk),
    .rst    (rst),
    .fire   (s1_fire),
    .item   (s1_item),
    .result (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_data <= result;
    end
  end

endmodule

[test/planar_octet_draw_unit_core_tb.sv]
// testbench of the planar octet draw unit: directed and random bus accesses checked per beat
module planar_octet_draw_unit_core_tb;
  import podu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // operation code that the block leaves unused
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned IDLE_PCT = 36;
  localparam int unsigned RANDOM_ACCESSES = 1500;
  localparam int unsigned BURST_ACCESSES = 200;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  podu_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  podu_out_t out_data;

  // register copy of the drawing unit
  logic [2:0]  shadow_colour = '0;
  logic [15:0] shadow_bg_low = '0;
  logic [15:0] shadow_bg_high = '0;
  logic [7:0]  shadow_octet = '0;
  logic [2:0]  shadow_inhibit = '0;

  podu_out_t pending_results[$];
  int unsigned error_count = 0;
  int unsigned access_count = 0;
  int unsigned draw_count = 0;
  int unsigned result_count = 0;
  bit          no_idle = 1'b0;

  planar_octet_draw_unit_core DUT (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always #6 clk = ~clk;

  // upper bound on the whole run
  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // result side stalls at random unless a burst is running
  always @(posedge clk) begin
    out_stall <= no_idle ? 1'b0 : ($urandom_range(99) < IDLE_PCT);
  end

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  task automatic compare_field(input string what, input logic [15:0] got,
                               input logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  // next state of the register copy and the result of one access
  function automatic podu_out_t predict_access(input podu_in_t acc);
    podu_out_t   res;
    logic [15:0] word;
    logic [31:0] bg;
    logic [2:0][7:0] drawn;
    res = '0;
    word = '0;
    if (acc.operation == OP_READ || acc.operation == OP_PEEK) begin
      case (acc.reg_index)
        REG_COLOUR:  word = {13'd0, shadow_colour};
        REG_BG_LOW:  word = shadow_bg_low;
        REG_BG_HIGH: word = shadow_bg_high;
        REG_MASK:    word = {13'd0, shadow_inhibit};
        REG_OCTET: begin
          // normal read packs the screen bytes into the background, answers zero
          if (acc.operation == OP_READ) begin
            bg = '0;
            for (int k = 0; k < 8; k++) begin
              bg[4*k]     = acc.plane_zero_byte[k];
              bg[4*k + 1] = acc.plane_one_byte[k];
              bg[4*k + 2] = acc.plane_two_byte[k];
            end
            {shadow_bg_high, shadow_bg_low} = bg;
          end
        end
        default: word = '0;
      endcase
      if (acc.byte_access) word = acc.byte_lane ? {8'd0, word[15:8]} : {8'd0, word[7:0]};
      res.read_result = word;
    end else if (acc.operation == OP_WRITE) begin
      if (!acc.byte_access) word = acc.write_data;
      else if (acc.byte_lane) word = {acc.write_data[7:0], 8'd0};
      else word = {8'd0, acc.write_data[7:0]};
      case (acc.reg_index)
        REG_COLOUR:  shadow_colour = word[2:0];
        REG_BG_LOW:  shadow_bg_low = word;
        REG_BG_HIGH: shadow_bg_high = word;
        REG_MASK:    shadow_inhibit = word[2:0];
        REG_OCTET: begin
          // set octet bits take the colour, clear bits keep the background dot
          shadow_octet = word[7:0];
          bg = {shadow_bg_high, shadow_bg_low};
          for (int p = 0; p < 3; p++) begin
            for (int k = 0; k < 8; k++) begin
              drawn[p][k] = shadow_octet[k] ? shadow_colour[p] : bg[4*k + p];
            end
          end
          res.plane_write_enables = ~shadow_inhibit;
          res.plane_write_address = acc.screen_address;
          if (!shadow_inhibit[0]) res.plane_zero_out = drawn[0];
          if (!shadow_inhibit[1]) res.plane_one_out = drawn[1];
          if (!shadow_inhibit[2]) res.plane_two_out = drawn[2];
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  // access with random screen address and screen bytes
  function automatic podu_in_t make_access(input logic [1:0] op, input logic [2:0] idx,
                                           input logic is_byte, input logic lane,
                                           input logic [15:0] data);
    podu_in_t acc;
    acc.operation = op;
    acc.reg_index = idx;
    acc.byte_access = is_byte;
    acc.byte_lane = lane;
    acc.write_data = data;
    acc.screen_address = 16'($urandom);
    acc.plane_zero_byte = 8'($urandom);
    acc.plane_one_byte = 8'($urandom);
    acc.plane_two_byte = 8'($urandom);
    return acc;
  endfunction

  // one beat into the block; valid stays high when the next beat follows at once
  task automatic send_access(input podu_in_t acc);
    podu_out_t res;
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= acc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    res = predict_access(acc);
    if (res.plane_write_enables != '0) draw_count++;
    pending_results = {pending_results, res};
    access_count++;
  endtask

  // every accepted result against the oldest prediction
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result beat with nothing pending", out_data.read_result, '0);
      end else begin
        podu_out_t want;
        want = pending_results.pop_front();
        compare_field("read_result", out_data.read_result, want.read_result);
        compare_field("plane_write_enables", 16'(out_data.plane_write_enables),
                      16'(want.plane_write_enables));
        compare_field("plane_write_address", out_data.plane_write_address,
                      want.plane_write_address);
        compare_field("plane_zero_out", 16'(out_data.plane_zero_out),
                      16'(want.plane_zero_out));
        compare_field("plane_one_out", 16'(out_data.plane_one_out), 16'(want.plane_one_out));
        compare_field("plane_two_out", 16'(out_data.plane_two_out), 16'(want.plane_two_out));
        result_count++;
      end
    end
  end

  // register writes and reads, byte lanes, empty indexes, unused operation
  task automatic test_register_access();
    podu_in_t acc;
    send_access(make_access(OP_PEEK, REG_COLOUR, 1'b0, 1'b0, 16'h0000));
    send_access(make_access(OP_WRITE, REG_COLOUR, 1'b0, 1'b0, 16'hFFFF));
    send_access(make_access(OP_READ, REG_COLOUR, 1'b0, 1'b0, 16'h0000));
    send_access(make_access(OP_READ, REG_COLOUR, 1'b1, 1'b1, 16'h0000));
    send_access(make_access(OP_PEEK, REG_COLOUR, 1'b1, 1'b0, 16'h0000));
    send_access(make_access(OP_WRITE, REG_BG_LOW, 1'b1, 1'b1, 16'h12AB));
    send_access(make_access(OP_READ, REG_BG_LOW, 1'b0, 1'b0, 16'h0000));
    send_access(make_access(OP_WRITE, REG_BG_HIGH, 1'b0, 1'b0, 16'hFFFF));
    send_access(make_access(OP_PEEK, REG_BG_HIGH, 1'b1, 1'b1, 16'h0000));
    send_access(make_access(OP_WRITE, REG_MASK, 1'b0, 1'b0, 16'hFFF8));
    send_access(make_access(OP_READ, REG_MASK, 1'b0, 1'b0, 16'h0000));
    // empty indexes and the unused operation code, all bits set
    send_access(make_access(OP_READ, 3'd5, 1'b0, 1'b0, 16'h0000));
    send_access(make_access(OP_WRITE, 3'd7, 1'b0, 1'b0, 16'hFFFF));
    acc = '1;
    acc.operation = OP_UNUSED;
    send_access(acc);
  endtask

  // draws at the address extremes, byte lanes, background load and plane mask
  task automatic test_octet_draw();
    podu_in_t acc;
    acc = make_access(OP_WRITE, REG_OCTET, 1'b0, 1'b0, 16'h00FF);
    acc.screen_address = 16'hFFFF;
    send_access(acc);
    acc = make_access(OP_WRITE, REG_OCTET, 1'b0, 1'b0, 16'hFF00);
    acc.screen_address = 16'h0000;
    send_access(acc);
    // high-lane byte to the octet draws an all-clear octet
    send_access(make_access(OP_WRITE, REG_OCTET, 1'b1, 1'b1, 16'h005A));
    send_access(make_access(OP_WRITE, REG_OCTET, 1'b1, 1'b0, 16'hFFA5));
    acc = make_access(OP_READ, REG_OCTET, 1'b0, 1'b0, 16'h0000);
    acc.plane_zero_byte = 8'hFF;
    acc.plane_one_byte = 8'h00;
    acc.plane_two_byte = 8'hFF;
    send_access(acc);
    send_access(make_access(OP_PEEK, REG_OCTET, 1'b0, 1'b0, 16'h0000));
    send_access(make_access(OP_READ, REG_BG_LOW, 1'b0, 1'b0, 16'h0000));
    send_access(make_access(OP_READ, REG_OCTET, 1'b1, 1'b1, 16'h0000));
    send_access(make_access(OP_PEEK, REG_BG_HIGH, 1'b0, 1'b0, 16'h0000));
    send_access(make_access(OP_WRITE, REG_MASK, 1'b0, 1'b0, 16'h0007));
    send_access(make_access(OP_WRITE, REG_OCTET, 1'b0, 1'b0, 16'h0F0F));
    send_access(make_access(OP_WRITE, REG_MASK, 1'b1, 1'b0, 16'h0005));
    send_access(make_access(OP_WRITE, REG_COLOUR, 1'b0, 1'b0, 16'h0000));
    send_access(make_access(OP_WRITE, REG_OCTET, 1'b0, 1'b0, 16'h00C3));
  endtask

  // random accesses weighted toward draws and background loads
  task automatic test_random_access(input int unsigned count);
    podu_in_t    acc;
    int unsigned pick;
    logic [1:0]  op;
    for (int unsigned i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      acc = make_access(OP_READ, 3'($urandom), 1'($urandom), 1'($urandom), 16'($urandom));
      if (pick < 30) begin
        acc.operation = OP_WRITE;
        acc.reg_index = REG_OCTET;
      end else if (pick < 38) begin
        acc.reg_index = REG_OCTET;
      end else if (pick < 55) begin
        acc.operation = OP_WRITE;
        acc.reg_index = 3'($urandom_range(4));
      end else begin
        op = 2'($urandom_range(2));
        if ($urandom_range(19) == 0) op = OP_UNUSED;
        acc.operation = op;
      end
      send_access(acc);
    end
  endtask

  // back-to-back beats with no idling on either side
  task automatic test_back_to_back();
    no_idle = 1'b1;
    test_random_access(BURST_ACCESSES);
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_register_access();
    test_octet_draw();
    test_random_access(RANDOM_ACCESSES / 2);
    test_back_to_back();
    test_random_access(RANDOM_ACCESSES / 2);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    $display("run covered %0d accesses, %0d of them plane draws", access_count, draw_count);
    $display("%0d result beats checked, %0d mismatches", result_count, error_count);
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
